// File: design/maf_pkg.sv
// shared types, constants and the multiply program of the attitude filter
`default_nettype none

package maf_pkg;

    localparam int MW = 36;   // multiplier operand width, signed
    localparam int AW = 66;   // accumulator width, signed
    localparam int RW = 31;   // root and quotient width
    localparam int XW = 62;   // radicand / dividend width

    localparam logic signed [31:0] Q30_ONE = 32'sh4000_0000;

    localparam logic [5:0] PC_ERR  = 6'd0;
    localparam logic [5:0] PC_INT  = 6'd12;
    localparam logic [5:0] PC_PROP = 6'd18;
    localparam logic [5:0] PC_RATE = 6'd21;
    localparam logic [5:0] PC_SUM  = 6'd40;

    localparam logic [1:0] CFG_KP = 2'd0;
    localparam logic [1:0] CFG_KI = 2'd1;
    localparam logic [1:0] CFG_DT = 2'd2;

    typedef enum logic [4:0] {
        SRC_QW, SRC_QX, SRC_QY, SRC_QZ,
        SRC_AN0, SRC_AN1, SRC_AN2,
        SRC_HV0, SRC_HV1, SRC_HV2,
        SRC_ERR0, SRC_ERR1, SRC_ERR2,
        SRC_KP, SRC_KI, SRC_DT, SRC_TMP,
        SRC_RATE0, SRC_RATE1, SRC_RATE2,
        SRC_H0, SRC_H1, SRC_H2,
        SRC_ONE16,
        SRC_MAG0, SRC_MAG1, SRC_MAG2, SRC_MAG3
    } t_src;

    typedef enum logic [4:0] {
        DST_NONE,
        DST_HV0, DST_HV1, DST_HV2,
        DST_ERR0, DST_ERR1, DST_ERR2,
        DST_TMP,
        DST_INT0, DST_INT1, DST_INT2,
        DST_P0, DST_P1, DST_P2,
        DST_H0, DST_H1, DST_H2,
        DST_NQ0, DST_NQ1, DST_NQ2, DST_NQ3,
        DST_SUM
    } t_dst;

    typedef enum logic [3:0] {
        ST_IDLE, ST_NABS, ST_NSHIFT, ST_NSCALE, ST_NSQRT, ST_NSQRT_WAIT,
        ST_NDIV, ST_NDIV_WAIT, ST_MAC, ST_DRAIN, ST_FINISH
    } t_state;

    // one product term; a term with a destination closes its sum
    typedef struct packed {
        t_src a;
        t_src b;
        logic neg;
        t_dst dst;
    } t_uop;

    typedef struct packed {
        logic                 valid;
        logic signed [MW-1:0] a;
        logic signed [MW-1:0] b;
        logic                 neg;
        t_dst                 dst;
    } t_mac_req;

    typedef struct packed {
        logic                 valid;
        t_dst                 dst;
        logic signed [AW-1:0] acc;
    } t_mac_res;

    typedef struct packed {
        logic          start;
        logic          sqrt;
        logic [XW-1:0] x;
        logic [RW-1:0] div;
    } t_rd_req;

    typedef struct packed {
        logic          done;
        logic [RW-1:0] res;
    } t_rd_res;

    function automatic t_uop mk(input t_src a, input t_src b, input logic neg,
                                input t_dst dst);
        t_uop u;
        u.a   = a;
        u.b   = b;
        u.neg = neg;
        u.dst = dst;
        return u;
    endfunction

    function automatic t_uop maf_ucode(input logic [5:0] pc);
        t_uop u;
        case (pc)
            // gravity half vector
            6'd0:  u = mk(SRC_QX, SRC_QZ, 1'b0, DST_NONE);
            6'd1:  u = mk(SRC_QW, SRC_QY, 1'b1, DST_HV0);
            6'd2:  u = mk(SRC_QW, SRC_QX, 1'b0, DST_NONE);
            6'd3:  u = mk(SRC_QY, SRC_QZ, 1'b0, DST_HV1);
            6'd4:  u = mk(SRC_QW, SRC_QW, 1'b0, DST_NONE);
            6'd5:  u = mk(SRC_QZ, SRC_QZ, 1'b0, DST_HV2);
            // cross product error
            6'd6:  u = mk(SRC_AN1, SRC_HV2, 1'b0, DST_NONE);
            6'd7:  u = mk(SRC_AN2, SRC_HV1, 1'b1, DST_ERR0);
            6'd8:  u = mk(SRC_AN2, SRC_HV0, 1'b0, DST_NONE);
            6'd9:  u = mk(SRC_AN0, SRC_HV2, 1'b1, DST_ERR1);
            6'd10: u = mk(SRC_AN0, SRC_HV1, 1'b0, DST_NONE);
            6'd11: u = mk(SRC_AN1, SRC_HV0, 1'b1, DST_ERR2);
            // integral terms
            6'd12: u = mk(SRC_KI, SRC_ERR0, 1'b0, DST_TMP);
            6'd13: u = mk(SRC_TMP, SRC_DT, 1'b0, DST_INT0);
            6'd14: u = mk(SRC_KI, SRC_ERR1, 1'b0, DST_TMP);
            6'd15: u = mk(SRC_TMP, SRC_DT, 1'b0, DST_INT1);
            6'd16: u = mk(SRC_KI, SRC_ERR2, 1'b0, DST_TMP);
            6'd17: u = mk(SRC_TMP, SRC_DT, 1'b0, DST_INT2);
            // proportional terms
            6'd18: u = mk(SRC_KP, SRC_ERR0, 1'b0, DST_P0);
            6'd19: u = mk(SRC_KP, SRC_ERR1, 1'b0, DST_P1);
            6'd20: u = mk(SRC_KP, SRC_ERR2, 1'b0, DST_P2);
            // half-angle increments
            6'd21: u = mk(SRC_RATE0, SRC_DT, 1'b0, DST_H0);
            6'd22: u = mk(SRC_RATE1, SRC_DT, 1'b0, DST_H1);
            6'd23: u = mk(SRC_RATE2, SRC_DT, 1'b0, DST_H2);
            // quaternion update
            6'd24: u = mk(SRC_QW, SRC_ONE16, 1'b0, DST_NONE);
            6'd25: u = mk(SRC_QX, SRC_H0, 1'b1, DST_NONE);
            6'd26: u = mk(SRC_QY, SRC_H1, 1'b1, DST_NONE);
            6'd27: u = mk(SRC_QZ, SRC_H2, 1'b1, DST_NQ0);
            6'd28: u = mk(SRC_QX, SRC_ONE16, 1'b0, DST_NONE);
            6'd29: u = mk(SRC_QW, SRC_H0, 1'b0, DST_NONE);
            6'd30: u = mk(SRC_QY, SRC_H2, 1'b0, DST_NONE);
            6'd31: u = mk(SRC_QZ, SRC_H1, 1'b1, DST_NQ1);
            6'd32: u = mk(SRC_QY, SRC_ONE16, 1'b0, DST_NONE);
            6'd33: u = mk(SRC_QW, SRC_H1, 1'b0, DST_NONE);
            6'd34: u = mk(SRC_QX, SRC_H2, 1'b1, DST_NONE);
            6'd35: u = mk(SRC_QZ, SRC_H0, 1'b0, DST_NQ2);
            6'd36: u = mk(SRC_QZ, SRC_ONE16, 1'b0, DST_NONE);
            6'd37: u = mk(SRC_QW, SRC_H2, 1'b0, DST_NONE);
            6'd38: u = mk(SRC_QX, SRC_H1, 1'b0, DST_NONE);
            6'd39: u = mk(SRC_QY, SRC_H0, 1'b1, DST_NQ3);
            // sum of squares for normalisation
            6'd40: u = mk(SRC_MAG0, SRC_MAG0, 1'b0, DST_NONE);
            6'd41: u = mk(SRC_MAG1, SRC_MAG1, 1'b0, DST_NONE);
            6'd42: u = mk(SRC_MAG2, SRC_MAG2, 1'b0, DST_NONE);
            6'd43: u = mk(SRC_MAG3, SRC_MAG3, 1'b0, DST_SUM);
            default: u = mk(SRC_MAG3, SRC_MAG3, 1'b0, DST_SUM);
        endcase
        return u;
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [35:0] v);
        logic signed [31:0] r;
        if (v > 36'sd2147483647) begin
            r = 32'sh7fff_ffff;
        end else if (v < -36'sd2147483648) begin
            r = 32'sh8000_0000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// File: design/mahony_attitude_filter.sv
// mahony attitude filter top level: sequencer, register file and shared units
// work per word: two normalisations (one bit per cycle magnitude shift,
//   square root and three or four divides) and the multiply-accumulate
//   program through one shared multiplier; a free-fall word skips the
//   accelerometer normalisation and the correction
// one word at a time: the next word is taken once the result sits
//   in the output register, which waits there for m_axis_tready
// reset (synchronous, active low): gains and period to defaults, attitude to
//   identity, integrators cleared, no word pending
`default_nettype none

module mahony_attitude_filter
    import maf_pkg::*;
(
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    // input words
    input  wire logic          s_axis_tvalid,
    output logic               s_axis_tready,
    // rate_x, rate_y, rate_z (32 each), acc_x, acc_y, acc_z (16 each)
    input  wire logic [143:0]  s_axis_tdata,
    // result words
    output logic               m_axis_tvalid,
    input  wire logic          m_axis_tready,
    // quat_w, quat_x, quat_y, quat_z (32 each)
    output logic [127:0]       m_axis_tdata,
    // register writes
    input  wire logic          i_cfg_valid,
    output logic               o_cfg_ready,
    input  wire logic [1:0]    i_cfg_index,
    input  wire logic [23:0]   i_cfg_data
);

    t_state r_state, n_state;
    logic [5:0] r_pc, n_pc;
    logic       r_pass, n_pass;   // low: accelerometer, high: quaternion
    logic [1:0] r_lane, n_lane;
    logic [4:0] r_k, n_k;

    logic [23:0] r_kp, r_ki, r_dt;

    logic signed [31:0] r_q   [4];
    logic signed [31:0] r_ei  [3];
    logic signed [32:0] r_rate[3];
    logic signed [63:0] r_v   [4];
    logic        [63:0] r_mag [4];
    logic signed [31:0] r_an  [3];
    logic signed [32:0] r_hv  [3];
    logic signed [33:0] r_err [3];
    logic signed [35:0] r_tmp;
    logic signed [31:0] r_h   [3];
    logic        [63:0] r_sum;
    logic [RW-1:0]      r_root;

    logic         r_m_valid;
    logic [127:0] r_m_data;

    t_mac_req w_mac_req;
    t_mac_res w_mac_res;
    t_rd_req  w_rd_req;
    t_rd_res  w_rd_res;
    t_uop     w_uop;

    logic               w_zero;
    logic               w_big;
    logic               w_last_lane;
    logic [63:0]        w_dividend;
    logic signed [31:0] w_qs;
    logic               w_out_free;

    maf_mac u_mac (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_mac_req),
        .o_res   (w_mac_res)
    );

    maf_rootdiv u_rootdiv (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_rd_req),
        .o_res   (w_rd_res)
    );

    assign w_uop = maf_ucode(r_pc);

    // operand selection for the shared multiplier
    function automatic logic signed [MW-1:0] pick(input t_src s);
        logic signed [MW-1:0] r;
        case (s)
            SRC_QW:    r = MW'(r_q[0]);
            SRC_QX:    r = MW'(r_q[1]);
            SRC_QY:    r = MW'(r_q[2]);
            SRC_QZ:    r = MW'(r_q[3]);
            SRC_AN0:   r = MW'(r_an[0]);
            SRC_AN1:   r = MW'(r_an[1]);
            SRC_AN2:   r = MW'(r_an[2]);
            SRC_HV0:   r = MW'(r_hv[0]);
            SRC_HV1:   r = MW'(r_hv[1]);
            SRC_HV2:   r = MW'(r_hv[2]);
            SRC_ERR0:  r = MW'(r_err[0]);
            SRC_ERR1:  r = MW'(r_err[1]);
            SRC_ERR2:  r = MW'(r_err[2]);
            SRC_KP:    r = {{(MW-24){1'b0}}, r_kp};
            SRC_KI:    r = {{(MW-24){1'b0}}, r_ki};
            SRC_DT:    r = {{(MW-24){1'b0}}, r_dt};
            SRC_TMP:   r = r_tmp;
            SRC_RATE0: r = MW'(r_rate[0]);
            SRC_RATE1: r = MW'(r_rate[1]);
            SRC_RATE2: r = MW'(r_rate[2]);
            SRC_H0:    r = MW'(r_h[0]);
            SRC_H1:    r = MW'(r_h[1]);
            SRC_H2:    r = MW'(r_h[2]);
            SRC_ONE16: r = MW'(65536);
            SRC_MAG0:  r = {{(MW-30){1'b0}}, r_mag[0][29:0]};
            SRC_MAG1:  r = {{(MW-30){1'b0}}, r_mag[1][29:0]};
            SRC_MAG2:  r = {{(MW-30){1'b0}}, r_mag[2][29:0]};
            SRC_MAG3:  r = {{(MW-30){1'b0}}, r_mag[3][29:0]};
            default:   r = '0;
        endcase
        return r;
    endfunction

    // normalisation helpers
    assign w_zero = (r_v[0] == 64'sd0) && (r_v[1] == 64'sd0) &&
                    (r_v[2] == 64'sd0) && (r_v[3] == 64'sd0);
    assign w_big  = (r_mag[0][63:30] != '0) || (r_mag[1][63:30] != '0) ||
                    (r_mag[2][63:30] != '0) || (r_mag[3][63:30] != '0);
    assign w_last_lane = r_pass ? (r_lane == 2'd3) : (r_lane == 2'd2);
    // magnitude times 2^(30+k), always below 2^61
    assign w_dividend  = {34'd0, r_mag[r_lane][29:0]} << (6'd30 + {1'b0, r_k});
    assign w_qs = r_v[r_lane][63] ? -$signed({1'b0, w_rd_res.res})
                                  :  $signed({1'b0, w_rd_res.res});
    assign w_out_free = !r_m_valid || m_axis_tready;

    // ---------------------------------------------------------------
    // sequencer
    // ---------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_pc    <= PC_ERR;
            r_pass  <= 1'b0;
            r_lane  <= 2'd0;
            r_k     <= 5'd0;
        end else begin
            r_state <= n_state;
            r_pc    <= n_pc;
            r_pass  <= n_pass;
            r_lane  <= n_lane;
            r_k     <= n_k;
        end
    end

    always_comb begin
        n_state = r_state;
        n_pc    = r_pc;
        n_pass  = r_pass;
        n_lane  = r_lane;
        n_k     = r_k;

        w_mac_req.valid = 1'b0;
        w_mac_req.a     = pick(w_uop.a);
        w_mac_req.b     = pick(w_uop.b);
        w_mac_req.neg   = w_uop.neg;
        w_mac_req.dst   = w_uop.dst;

        w_rd_req.start = 1'b0;
        w_rd_req.sqrt  = (r_state == ST_NSQRT);
        w_rd_req.x     = (r_state == ST_NSQRT) ? r_sum[XW-1:0] : w_dividend[XW-1:0];
        w_rd_req.div   = r_root;

        s_axis_tready = (r_state == ST_IDLE);

        case (r_state)
            ST_IDLE: begin
                if (s_axis_tvalid) begin
                    n_state = ST_NABS;
                    n_pass  = 1'b0;
                end
            end
            ST_NABS: begin
                n_k = 5'd0;
                if (w_zero) begin
                    // no accelerometer: straight to the rate integration; a zero update finishes
                    n_state = r_pass ? ST_FINISH : ST_MAC;
                    n_pc    = PC_RATE;
                end else begin
                    n_state = ST_NSHIFT;
                end
            end
            ST_NSHIFT: begin
                if (!w_big) begin
                    n_state = ST_MAC;
                    n_pc    = PC_SUM;
                end
            end
            ST_MAC: begin
                w_mac_req.valid = 1'b1;
                if (w_uop.dst != DST_NONE) begin
                    n_state = ST_DRAIN;
                end else begin
                    n_pc = r_pc + 6'd1;
                end
            end
            ST_DRAIN: begin
                if (w_mac_res.valid) begin
                    n_state = ST_MAC;
                    n_pc    = r_pc + 6'd1;
                    case (w_mac_res.dst)
                        DST_SUM: n_state = ST_NSCALE;
                        DST_ERR2: n_pc = (r_ki != 24'd0) ? PC_INT : PC_PROP;
                        DST_NQ3: begin
                            n_state = ST_NABS;
                            n_pass  = 1'b1;
                        end
                        default: ;
                    endcase
                end
            end
            ST_NSCALE: begin
                if (r_sum[63:60] == 4'd0) begin
                    n_k = r_k + 5'd1;
                end else begin
                    n_state = ST_NSQRT;
                end
            end
            ST_NSQRT: begin
                w_rd_req.start = 1'b1;
                n_state        = ST_NSQRT_WAIT;
            end
            ST_NSQRT_WAIT: begin
                if (w_rd_res.done) begin
                    n_state = ST_NDIV;
                    n_lane  = 2'd0;
                end
            end
            ST_NDIV: begin
                w_rd_req.start = 1'b1;
                n_state        = ST_NDIV_WAIT;
            end
            ST_NDIV_WAIT: begin
                if (w_rd_res.done) begin
                    if (w_last_lane) begin
                        n_state = r_pass ? ST_FINISH : ST_MAC;
                        n_pc    = PC_ERR;
                    end else begin
                        n_state = ST_NDIV;
                        n_lane  = r_lane + 2'd1;
                    end
                end
            end
            ST_FINISH: begin
                if (w_out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // ---------------------------------------------------------------
    // datapath registers
    // ---------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        logic signed [35:0] v_sum;
        logic signed [31:0] v_ei;
        v_sum = '0;
        v_ei  = '0;
        case (r_state)
            ST_IDLE: begin
                if (s_axis_tvalid) begin
                    r_rate[0] <= 33'(signed'(s_axis_tdata[31:0]));
                    r_rate[1] <= 33'(signed'(s_axis_tdata[63:32]));
                    r_rate[2] <= 33'(signed'(s_axis_tdata[95:64]));
                    r_v[0]    <= 64'(signed'(s_axis_tdata[111:96]));
                    r_v[1]    <= 64'(signed'(s_axis_tdata[127:112]));
                    r_v[2]    <= 64'(signed'(s_axis_tdata[143:128]));
                    r_v[3]    <= 64'sd0;
                end
            end
            ST_NABS: begin
                for (int i = 0; i < 4; i++) begin
                    r_mag[i] <= r_v[i][63] ? 64'(-r_v[i]) : 64'(r_v[i]);
                end
            end
            ST_NSHIFT: begin
                if (w_big) begin
                    for (int i = 0; i < 4; i++) begin
                        r_mag[i] <= r_mag[i] >> 1;
                    end
                end
            end
            ST_NSCALE: begin
                if (r_sum[63:60] == 4'd0) begin
                    r_sum <= r_sum << 2;
                end
            end
            ST_NSQRT_WAIT: begin
                if (w_rd_res.done) begin
                    r_root <= w_rd_res.res;
                end
            end
            default: ;
        endcase

        // results of the multiply program
        if (w_mac_res.valid) begin
            case (w_mac_res.dst)
                DST_HV0:  r_hv[0]  <= w_mac_res.acc[62:30];
                DST_HV1:  r_hv[1]  <= w_mac_res.acc[62:30];
                DST_HV2:  r_hv[2]  <= w_mac_res.acc[62:30] - 33'sd536870912;
                DST_ERR0: r_err[0] <= w_mac_res.acc[63:30];
                DST_ERR1: r_err[1] <= w_mac_res.acc[63:30];
                DST_ERR2: r_err[2] <= w_mac_res.acc[63:30];
                DST_TMP:  r_tmp    <= w_mac_res.acc[57:22];
                DST_INT0, DST_INT1, DST_INT2: begin
                    for (int i = 0; i < 3; i++) begin
                        if (w_mac_res.dst == t_dst'(DST_INT0 + i)) begin
                            v_ei = sat32(36'(r_ei[i]) + 36'(signed'(w_mac_res.acc[65:32])));
                            r_ei[i]   <= v_ei;
                            r_rate[i] <= r_rate[i] + 33'(v_ei);
                        end
                    end
                end
                DST_P0, DST_P1, DST_P2: begin
                    for (int i = 0; i < 3; i++) begin
                        if (w_mac_res.dst == t_dst'(DST_P0 + i)) begin
                            v_sum = 36'(r_rate[i]) + w_mac_res.acc[65:30];
                            r_rate[i] <= 33'(sat32(v_sum));
                        end
                    end
                end
                DST_H0:  r_h[0] <= w_mac_res.acc[56:25];
                DST_H1:  r_h[1] <= w_mac_res.acc[56:25];
                DST_H2:  r_h[2] <= w_mac_res.acc[56:25];
                DST_NQ0: r_v[0] <= w_mac_res.acc[63:0];
                DST_NQ1: r_v[1] <= w_mac_res.acc[63:0];
                DST_NQ2: r_v[2] <= w_mac_res.acc[63:0];
                DST_NQ3: r_v[3] <= w_mac_res.acc[63:0];
                DST_SUM: r_sum  <= w_mac_res.acc[63:0];
                default: ;
            endcase
        end

        // normalised components of the accelerometer
        if (r_state == ST_NDIV_WAIT && w_rd_res.done && !r_pass) begin
            for (int i = 0; i < 3; i++) begin
                if (r_lane == 2'(i)) begin
                    r_an[i] <= w_qs;
                end
            end
        end

        if (r_state == ST_FINISH && w_out_free) begin
            r_m_data <= {r_q[3], r_q[2], r_q[1], r_q[0]};
        end

        if (!i_rst_n) begin
            r_kp      <= 24'd65536;
            r_ki      <= 24'd0;
            r_dt      <= 24'd838861;
            r_q[0]    <= Q30_ONE;
            r_q[1]    <= 32'sd0;
            r_q[2]    <= 32'sd0;
            r_q[3]    <= 32'sd0;
            r_ei[0]   <= 32'sd0;
            r_ei[1]   <= 32'sd0;
            r_ei[2]   <= 32'sd0;
            r_m_valid <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    CFG_KP:  r_kp <= i_cfg_data;
                    CFG_KI:  r_ki <= i_cfg_data;
                    CFG_DT:  r_dt <= i_cfg_data;
                    default: ;
                endcase
            end
            // zero integral gain clears the integrators
            if (w_mac_res.valid && w_mac_res.dst == DST_ERR2 && r_ki == 24'd0) begin
                r_ei[0] <= 32'sd0;
                r_ei[1] <= 32'sd0;
                r_ei[2] <= 32'sd0;
            end
            // new attitude, or identity when the update collapsed to zero
            if (r_state == ST_NABS && r_pass && w_zero) begin
                r_q[0] <= Q30_ONE;
                r_q[1] <= 32'sd0;
                r_q[2] <= 32'sd0;
                r_q[3] <= 32'sd0;
            end
            if (r_state == ST_NDIV_WAIT && w_rd_res.done && r_pass) begin
                r_q[r_lane] <= w_qs;
            end
            if (r_state == ST_FINISH && w_out_free) begin
                r_m_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_m_valid <= 1'b0;
            end
        end
    end

    assign o_cfg_ready   = 1'b1;
    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = r_m_data;

`ifndef NO_ASSERTIONS
    // a sum only completes while the sequencer waits for it
    a_mac_in_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_mac_res.valid |-> (r_state == ST_DRAIN))
        else $error("multiply result outside drain");

    // root or quotient only completes while the sequencer waits for it
    a_rd_in_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_rd_res.done |-> (r_state == ST_NSQRT_WAIT || r_state == ST_NDIV_WAIT))
        else $error("root unit result outside wait");

    // stored attitude stays a unit quaternion component
    a_q_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_q[0] <= Q30_ONE && r_q[0] >= -Q30_ONE && r_q[1] <= Q30_ONE &&
         r_q[1] >= -Q30_ONE && r_q[2] <= Q30_ONE && r_q[2] >= -Q30_ONE &&
         r_q[3] <= Q30_ONE && r_q[3] >= -Q30_ONE))
        else $error("attitude component out of range");

    // one word at a time
    a_one_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("second word taken while busy");
`endif

endmodule

`default_nettype wire

// File: design/maf_mac.sv
// shared multiply-accumulate unit, product register then accumulator
`default_nettype none

module maf_mac
    import maf_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire t_mac_req i_req,
    output t_mac_res      o_res
);

    logic signed [2*MW-1:0] w_full;
    logic signed [AW-1:0]   r_prod;
    logic                   r_v1;
    logic                   r_neg;
    t_dst                   r_dst;
    logic signed [AW-1:0]   r_acc;
    logic                   r_fresh;
    logic                   r_out_valid;
    t_dst                   r_out_dst;
    logic signed [AW-1:0]   w_term;

    assign w_full = i_req.a * i_req.b;
    assign w_term = r_neg ? -r_prod : r_prod;

    always_ff @(posedge i_clk) begin
        r_prod <= w_full[AW-1:0];
        r_neg  <= i_req.neg;
        r_dst  <= i_req.dst;
        if (r_v1) begin
            r_acc <= r_fresh ? w_term : r_acc + w_term;
        end
        r_out_dst <= r_dst;
        if (!i_rst_n) begin
            r_v1        <= 1'b0;
            r_fresh     <= 1'b1;
            r_out_valid <= 1'b0;
        end else begin
            r_v1        <= i_req.valid;
            r_out_valid <= r_v1 && (r_dst != DST_NONE);
            if (r_v1) begin
                r_fresh <= (r_dst != DST_NONE);
            end
        end
    end

    assign o_res.valid = r_out_valid;
    assign o_res.dst   = r_out_dst;
    assign o_res.acc   = r_acc;

endmodule

`default_nettype wire

// File: design/maf_rootdiv.sv
// bit-serial square root and divider sharing one compare and subtract
`default_nettype none

module maf_rootdiv
    import maf_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire t_rd_req i_req,
    output t_rd_res      o_res
);

    logic          r_busy;
    logic          r_done;
    logic [4:0]    r_cnt;
    logic          r_sqrt;
    logic [33:0]   r_rem;
    logic [RW-1:0] r_res;
    logic [XW-1:0] r_x;
    logic [RW-1:0] r_div;
    logic [33:0]   w_sh;
    logic [33:0]   w_trial;
    logic          w_ge;

    // sqrt brings down two radicand bits a step, divide one
    assign w_sh    = r_sqrt ? {r_rem[31:0], r_x[XW-1:XW-2]} : {r_rem[32:0], r_x[XW-1]};
    assign w_trial = r_sqrt ? {1'b0, r_res, 2'b01} : {3'b000, r_div};
    assign w_ge    = (w_sh >= w_trial);

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_sqrt <= i_req.sqrt;
            r_div  <= i_req.div;
            r_res  <= '0;
            r_cnt  <= '0;
            if (i_req.sqrt) begin
                r_rem <= '0;
                r_x   <= i_req.x;
            end else begin
                r_rem <= {3'b000, i_req.x[XW-1:RW]};
                r_x   <= {i_req.x[RW-1:0], {(XW-RW){1'b0}}};
            end
        end else if (r_busy) begin
            r_rem <= w_ge ? (w_sh - w_trial) : w_sh;
            r_res <= {r_res[RW-2:0], w_ge};
            r_x   <= r_sqrt ? {r_x[XW-3:0], 2'b00} : {r_x[XW-2:0], 1'b0};
            r_cnt <= r_cnt + 5'd1;
        end
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= r_busy && !i_req.start && (r_cnt == 5'(RW - 1));
            if (i_req.start) begin
                r_busy <= 1'b1;
            end else if (r_busy && (r_cnt == 5'(RW - 1))) begin
                r_busy <= 1'b0;
            end
        end
    end

    assign o_res.done = r_done;
    assign o_res.res  = r_res;

endmodule

`default_nettype wire
